>>> design/lprc_pkg.sv
package lprc_pkg;

   // Parse phases; the same codes serve as the byte role on the result side.
   typedef enum logic [2:0] {
      PHASE_HINT_LEN = 3'd0,
      PHASE_HINT_CHR = 3'd1,
      PHASE_ARGC     = 3'd2,
      PHASE_ARG_LEN  = 3'd3,
      PHASE_ARG_CHR  = 3'd4,
      PHASE_DONE     = 3'd5
   } phase_type;

   // Verdict codes
   localparam logic [1:0] VerdictPending  = 2'd0;
   localparam logic [1:0] VerdictAccepted = 2'd1;
   localparam logic [1:0] VerdictRejected = 2'd2;

   // Register indexes
   localparam logic [1:0] CsrMaxHintLength    = 2'd0;
   localparam logic [1:0] CsrMaxArgLength     = 2'd1;
   localparam logic [1:0] CsrMaxArgCount      = 2'd2;
   localparam logic [1:0] CsrMaxPayloadLength = 2'd3;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 17;

   // Register reset values
   localparam logic [11:0] MaxHintLengthReset    = 12'd256;
   localparam logic [15:0] MaxArgLengthReset     = 16'd4096;
   localparam logic [7:0]  MaxArgCountReset      = 8'd64;
   localparam logic [16:0] MaxPayloadLengthReset = 17'd65536;

   // Hard cap on the argument count, on top of the register
   localparam logic [7:0] ArgCountLimit = 8'd255;

   // Saturation point of the byte total
   localparam logic [16:0] TotalSat = 17'h1FFFF;

   // Last byte position within a 32-bit length word
   localparam logic [1:0] WordLastByte = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] byte_role;
      logic [7:0] arg_number;
      logic [1:0] verdict;
      logic [7:0] byte_echo;
   } rsp_payload_type;

endpackage

>>> design/lprc_stream_if.sv
interface lprc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/length_prefixed_request_checker_core.sv
// Channel     Direction  Payload
// req_stream  in         data_byte[7:0], last_byte
// rsp_stream  out        byte_role[2:0], arg_number[7:0], verdict[1:0], byte_echo[7:0]
// csr_*       in         write enable, 2-bit register index, 17-bit write data
//
// One request in, one response out; a new request is taken every cycle unless stalled.
// Each request is parsed in the cycle it is accepted; its response sits in
// the output register from the next cycle. The request side stalls only while
// that register is full and the response is not taken. Synchronous reset
// clears the parser and the output valid and loads the register defaults.
module length_prefixed_request_checker_core (
   input  logic                                   clock,
   input  logic                                   reset,
   lprc_stream_if.sink                            req_stream,
   lprc_stream_if.source                          rsp_stream,
   input  logic                                   csr_write_enable,
   input  logic [lprc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [lprc_pkg::CsrDataWidth-1:0]      csr_write_data
);

   // Configuration registers
   logic [11:0] max_hint_length_ff;
   logic [15:0] max_arg_length_ff;
   logic [7:0]  max_arg_count_ff;
   logic [16:0] max_payload_length_ff;

   // Parser state
   lprc_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  word_count_ff, word_count_in;
   logic [31:0] length_acc_ff, length_acc_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  expected_args_ff, expected_args_in;
   logic [7:0]  current_arg_ff, current_arg_in;
   logic [16:0] total_ff, total_in;
   logic        failed_ff, failed_in;

   // Output register
   logic                      out_valid_ff;
   lprc_pkg::rsp_payload_type out_payload_ff, out_payload_in;

   logic       req_accept;
   logic [7:0] arg_limit;

   assign req_stream.ready   = !out_valid_ff || rsp_stream.ready;
   assign req_accept         = req_stream.valid && req_stream.ready;
   assign rsp_stream.valid   = out_valid_ff;
   assign rsp_stream.payload = out_payload_ff;

   assign arg_limit = (max_arg_count_ff < lprc_pkg::ArgCountLimit) ?
                      max_arg_count_ff : lprc_pkg::ArgCountLimit;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_hint_length_ff    <= lprc_pkg::MaxHintLengthReset;
         max_arg_length_ff     <= lprc_pkg::MaxArgLengthReset;
         max_arg_count_ff      <= lprc_pkg::MaxArgCountReset;
         max_payload_length_ff <= lprc_pkg::MaxPayloadLengthReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lprc_pkg::CsrMaxHintLength:    max_hint_length_ff    <= csr_write_data[11:0];
            lprc_pkg::CsrMaxArgLength:     max_arg_length_ff     <= csr_write_data[15:0];
            lprc_pkg::CsrMaxArgCount:      max_arg_count_ff      <= csr_write_data[7:0];
            lprc_pkg::CsrMaxPayloadLength: max_payload_length_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Per-byte parse step
   always_comb begin
      logic [7:0]  b;
      logic [31:0] word;
      logic [2:0]  role;
      logic [7:0]  next_arg;

      b    = req_stream.payload.data_byte;
      word = {length_acc_ff[23:0], b};

      phase_in         = phase_ff;
      word_count_in    = word_count_ff;
      length_acc_in    = length_acc_ff;
      bytes_left_in    = bytes_left_ff;
      expected_args_in = expected_args_ff;
      current_arg_in   = current_arg_ff;
      total_in         = total_ff;
      failed_in        = failed_ff;
      next_arg         = current_arg_ff + 8'd1;

      // Role reflects the state before this byte
      role = failed_ff ? 3'(lprc_pkg::PHASE_DONE) : 3'(phase_ff);
      out_payload_in.byte_role  = role;
      out_payload_in.arg_number =
         (role == 3'(lprc_pkg::PHASE_ARG_LEN) || role == 3'(lprc_pkg::PHASE_ARG_CHR)) ?
         current_arg_ff : 8'd0;
      out_payload_in.byte_echo  = b;
      out_payload_in.verdict    = lprc_pkg::VerdictPending;

      // Saturating byte total
      if (total_ff == lprc_pkg::TotalSat) begin
         failed_in = 1'b1;
      end else begin
         total_in = total_ff + 17'd1;
         if (total_in > max_payload_length_ff) begin
            failed_in = 1'b1;
         end
      end

      if (!failed_in) begin
         case (phase_ff) inside
            lprc_pkg::PHASE_HINT_LEN, lprc_pkg::PHASE_ARGC, lprc_pkg::PHASE_ARG_LEN: begin
               length_acc_in = word;
               if (word_count_ff == lprc_pkg::WordLastByte) begin
                  word_count_in = 2'd0;
                  // Whole length word in hand
                  if (phase_ff == lprc_pkg::PHASE_HINT_LEN) begin
                     if (word == 32'd0 || word > {20'd0, max_hint_length_ff}) begin
                        failed_in = 1'b1;
                     end else begin
                        bytes_left_in = word[15:0];
                        phase_in      = lprc_pkg::PHASE_HINT_CHR;
                     end
                  end else if (phase_ff == lprc_pkg::PHASE_ARGC) begin
                     if (word > {24'd0, arg_limit}) begin
                        failed_in = 1'b1;
                     end else begin
                        expected_args_in = word[7:0];
                        current_arg_in   = 8'd0;
                        phase_in = (word[7:0] == 8'd0) ? lprc_pkg::PHASE_DONE :
                                                         lprc_pkg::PHASE_ARG_LEN;
                     end
                  end else begin
                     if (word > {16'd0, max_arg_length_ff}) begin
                        failed_in = 1'b1;
                     end else if (word == 32'd0) begin
                        current_arg_in = next_arg;
                        phase_in = (next_arg == expected_args_ff) ? lprc_pkg::PHASE_DONE :
                                                                    lprc_pkg::PHASE_ARG_LEN;
                     end else begin
                        bytes_left_in = word[15:0];
                        phase_in      = lprc_pkg::PHASE_ARG_CHR;
                     end
                  end
               end else begin
                  word_count_in = word_count_ff + 2'd1;
               end
            end
            lprc_pkg::PHASE_HINT_CHR, lprc_pkg::PHASE_ARG_CHR: begin
               if (b == 8'd0) begin
                  failed_in = 1'b1;
               end else if (bytes_left_ff <= 16'd1) begin
                  bytes_left_in = 16'd0;
                  if (phase_ff == lprc_pkg::PHASE_HINT_CHR) begin
                     phase_in = lprc_pkg::PHASE_ARGC;
                  end else begin
                     current_arg_in = next_arg;
                     phase_in = (next_arg == expected_args_ff) ? lprc_pkg::PHASE_DONE :
                                                                 lprc_pkg::PHASE_ARG_LEN;
                  end
               end else begin
                  bytes_left_in = bytes_left_ff - 16'd1;
               end
            end
            default: begin
               // Structure complete: any further byte is surplus
               failed_in = 1'b1;
            end
         endcase
      end

      // Final byte: give verdict and start over
      if (req_stream.payload.last_byte) begin
         out_payload_in.verdict = (!failed_in && phase_in == lprc_pkg::PHASE_DONE) ?
                                  lprc_pkg::VerdictAccepted : lprc_pkg::VerdictRejected;
         phase_in         = lprc_pkg::PHASE_HINT_LEN;
         word_count_in    = 2'd0;
         length_acc_in    = 32'd0;
         bytes_left_in    = 16'd0;
         expected_args_in = 8'd0;
         current_arg_in   = 8'd0;
         total_in         = 17'd0;
         failed_in        = 1'b0;
      end
   end

   // Parser state update on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= lprc_pkg::PHASE_HINT_LEN;
         word_count_ff    <= 2'd0;
         length_acc_ff    <= 32'd0;
         bytes_left_ff    <= 16'd0;
         expected_args_ff <= 8'd0;
         current_arg_ff   <= 8'd0;
         total_ff         <= 17'd0;
         failed_ff        <= 1'b0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         word_count_ff    <= word_count_in;
         length_acc_ff    <= length_acc_in;
         bytes_left_ff    <= bytes_left_in;
         expected_args_ff <= expected_args_in;
         current_arg_ff   <= current_arg_in;
         total_ff         <= total_in;
         failed_ff        <= failed_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_payload_ff <= out_payload_in;
      end
   end

endmodule
